@@ sv/msri_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msri_pkg
// shared types, codes and the control store of the run-increment sequencer
// ---------------------------------------------------------------------------
package msri_pkg;

   localparam int MAX_LENGTH_DEF = 64;
   localparam int VALUE_BITS_DEF = 16;

   localparam logic [6:0] LEN_RESET = 7'd64;

   // opcodes of an input word
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_INC   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // status codes of a result word
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_SAT   = 2'd2;

   typedef logic [3:0] step_type;

   // program addresses
   localparam step_type ST_IDLE      = 4'd0;
   localparam step_type ST_DECODE    = 4'd1;
   localparam step_type ST_CHK_OP    = 4'd2;
   localparam step_type ST_FETCH     = 4'd3;
   localparam step_type ST_LATCH     = 4'd4;
   localparam step_type ST_CHK_SAT   = 4'd5;
   localparam step_type ST_RUN_LO    = 4'd6;
   localparam step_type ST_RUN_HI    = 4'd7;
   localparam step_type ST_DONE_INC  = 4'd8;
   localparam step_type ST_CLR_INIT  = 4'd9;
   localparam step_type ST_CLR_STEP  = 4'd10;
   localparam step_type ST_DONE_ZERO = 4'd11;
   localparam step_type ST_DONE_RNG  = 4'd12;
   localparam step_type ST_DONE_READ = 4'd13;
   localparam step_type ST_DONE_SAT  = 4'd14;

   typedef enum logic [2:0] {
      UOP_NONE,
      UOP_READ,
      UOP_LATCH,
      UOP_SCAN_LO,
      UOP_SCAN_HI,
      UOP_CLR_INIT,
      UOP_CLR_STEP
   } uop_type;

   typedef enum logic [3:0] {
      C_ALWAYS,
      C_NOT_START,
      C_OP_CLEAR,
      C_OP_NONE,
      C_RANGE,
      C_OP_READ,
      C_SAT,
      C_LO_MATCH,
      C_HI_MATCH,
      C_CLR_MORE,
      C_NEVER
   } cond_type;

   typedef enum logic [2:0] {
      EM_NONE,
      EM_ZERO,
      EM_RANGE,
      EM_READ,
      EM_SAT,
      EM_INC
   } emit_type;

   typedef struct packed {
      uop_type  uop;
      cond_type cond;
      step_type target;
      emit_type emit;
   } ctrl_word_type;

   typedef struct packed {
      logic op_clear;
      logic op_none;
      logic op_read;
      logic range_err;
      logic sat;
      logic lo_match;
      logic hi_match;
      logic clr_more;
   } flags_type;

   // control store: jump to target when cond holds, else fall through
   function automatic ctrl_word_type rom_word(input step_type step);
      ctrl_word_type w;
      w = '{UOP_NONE, C_ALWAYS, ST_IDLE, EM_NONE};
      case (step)
         ST_IDLE:      w = '{UOP_NONE,     C_NOT_START, ST_IDLE,      EM_NONE};
         ST_DECODE:    w = '{UOP_NONE,     C_OP_CLEAR,  ST_CLR_INIT,  EM_NONE};
         ST_CHK_OP:    w = '{UOP_NONE,     C_OP_NONE,   ST_DONE_ZERO, EM_NONE};
         ST_FETCH:     w = '{UOP_READ,     C_RANGE,     ST_DONE_RNG,  EM_NONE};
         ST_LATCH:     w = '{UOP_LATCH,    C_OP_READ,   ST_DONE_READ, EM_NONE};
         ST_CHK_SAT:   w = '{UOP_NONE,     C_SAT,       ST_DONE_SAT,  EM_NONE};
         ST_RUN_LO:    w = '{UOP_SCAN_LO,  C_LO_MATCH,  ST_RUN_LO,    EM_NONE};
         ST_RUN_HI:    w = '{UOP_SCAN_HI,  C_HI_MATCH,  ST_RUN_HI,    EM_NONE};
         ST_DONE_INC:  w = '{UOP_NONE,     C_ALWAYS,    ST_IDLE,      EM_INC};
         ST_CLR_INIT:  w = '{UOP_CLR_INIT, C_NEVER,     ST_IDLE,      EM_NONE};
         ST_CLR_STEP:  w = '{UOP_CLR_STEP, C_CLR_MORE,  ST_CLR_STEP,  EM_NONE};
         ST_DONE_ZERO: w = '{UOP_NONE,     C_ALWAYS,    ST_IDLE,      EM_ZERO};
         ST_DONE_RNG:  w = '{UOP_NONE,     C_ALWAYS,    ST_IDLE,      EM_RANGE};
         ST_DONE_READ: w = '{UOP_NONE,     C_ALWAYS,    ST_IDLE,      EM_READ};
         ST_DONE_SAT:  w = '{UOP_NONE,     C_ALWAYS,    ST_IDLE,      EM_SAT};
         default:      w = '{UOP_NONE,     C_ALWAYS,    ST_IDLE,      EM_NONE};
      endcase
      return w;
   endfunction

endpackage

@@ sv/msri_useq.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msri_useq
// step counter, control store lookup and conditional jump logic
// ---------------------------------------------------------------------------
module msri_useq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  msri_pkg::flags_type    flags,
   output msri_pkg::ctrl_word_type cw,
   output logic                   busy
);

   msri_pkg::step_type step_ff;
   msri_pkg::step_type step_in;
   logic               take;

   assign cw   = msri_pkg::rom_word(step_ff);
   assign busy = (step_ff != msri_pkg::ST_IDLE);

   always_comb begin
      case (cw.cond)
         msri_pkg::C_ALWAYS:    take = 1'b1;
         msri_pkg::C_NOT_START: take = !start;
         msri_pkg::C_OP_CLEAR:  take = flags.op_clear;
         msri_pkg::C_OP_NONE:   take = flags.op_none;
         msri_pkg::C_RANGE:     take = flags.range_err;
         msri_pkg::C_OP_READ:   take = flags.op_read;
         msri_pkg::C_SAT:       take = flags.sat;
         msri_pkg::C_LO_MATCH:  take = flags.lo_match;
         msri_pkg::C_HI_MATCH:  take = flags.hi_match;
         msri_pkg::C_CLR_MORE:  take = flags.clr_more;
         default:               take = 1'b0;
      endcase
      step_in = take ? cw.target : step_ff + 4'd1;
   end

   // reset enters the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= msri_pkg::ST_CLR_INIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ sv/msri_dpath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msri_dpath
// counter memory, scan pointer, compare flags and result register
// ---------------------------------------------------------------------------
module msri_dpath #(
   parameter int MAX_LENGTH = msri_pkg::MAX_LENGTH_DEF,
   parameter int VALUE_BITS = msri_pkg::VALUE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [1:0]              req_opcode,
   input  logic [5:0]              req_position,
   input  logic [6:0]              len,
   input  msri_pkg::ctrl_word_type cw,
   output msri_pkg::flags_type     flags,
   output logic                    rsp_strobe,
   output logic [15:0]             rsp_value,
   output logic [5:0]              rsp_run_begin,
   output logic [6:0]              rsp_run_end,
   output logic [1:0]              rsp_status
);

   localparam int AW = $clog2(MAX_LENGTH);

   logic [VALUE_BITS-1:0] mem [MAX_LENGTH];
   logic [VALUE_BITS-1:0] rdata_ff;

   logic [1:0]            op_ff;
   logic [5:0]            pos_ff;
   logic [AW:0]           ptr_ff, ptr_in;
   logic [VALUE_BITS-1:0] old_ff, old_in;
   logic                  pending_ff, pending_in;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [15:0]           rsp_value_ff, rsp_value_in;
   logic [5:0]            rsp_run_begin_ff, rsp_run_begin_in;
   logic [6:0]            rsp_run_end_ff, rsp_run_end_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_wa, mem_ra;
   logic [VALUE_BITS-1:0] mem_wd;
   logic [AW:0]           ptr_dec, ptr_inc;
   logic [VALUE_BITS-1:0] old_inc;
   logic                  ptr_ok;

   assign ptr_dec = ptr_ff - 1'b1;
   assign ptr_inc = ptr_ff + 1'b1;
   assign old_inc = old_ff + 1'b1;
   assign ptr_ok  = !ptr_ff[AW];

   always_comb begin
      flags.op_clear  = (op_ff == msri_pkg::OP_CLEAR);
      flags.op_read   = (op_ff == msri_pkg::OP_READ);
      flags.op_none   = (op_ff != msri_pkg::OP_CLEAR) && (op_ff != msri_pkg::OP_READ)
                        && (op_ff != msri_pkg::OP_INC);
      flags.range_err = ({1'b0, pos_ff} >= len) || (32'(pos_ff) >= 32'(MAX_LENGTH));
      flags.sat       = (old_ff == {VALUE_BITS{1'b1}});
      flags.lo_match  = ptr_ok && (rdata_ff == old_ff);
      flags.hi_match  = ptr_ok && (rdata_ff == old_inc);
      flags.clr_more  = (ptr_ff[AW-1:0] != AW'(MAX_LENGTH - 1));
   end

   // datapath actions of the current control word
   always_comb begin
      mem_we = 1'b0;
      mem_wa = ptr_ff[AW-1:0];
      mem_wd = '0;
      mem_re = 1'b0;
      mem_ra = ptr_ff[AW-1:0];
      ptr_in = ptr_ff;
      old_in = old_ff;
      if (accept) begin
         ptr_in = (AW+1)'(req_position);
      end
      case (cw.uop)
         msri_pkg::UOP_READ: begin
            mem_re = 1'b1;
         end
         msri_pkg::UOP_LATCH: begin
            old_in = rdata_ff;
         end
         msri_pkg::UOP_SCAN_LO: begin
            if (flags.lo_match) begin
               mem_we = 1'b1;
               mem_wd = old_inc;
               ptr_in = ptr_dec;
               mem_re = !ptr_dec[AW];
               mem_ra = ptr_dec[AW-1:0];
            end
         end
         msri_pkg::UOP_SCAN_HI: begin
            if (flags.hi_match) begin
               ptr_in = ptr_dec;
               mem_re = !ptr_dec[AW];
               mem_ra = ptr_dec[AW-1:0];
            end
         end
         msri_pkg::UOP_CLR_INIT: begin
            ptr_in = '0;
         end
         msri_pkg::UOP_CLR_STEP: begin
            mem_we = 1'b1;
            ptr_in = ptr_inc;
         end
         default: begin
         end
      endcase
   end

   // result formatting
   always_comb begin
      rsp_strobe_in    = 1'b0;
      rsp_value_in     = '0;
      rsp_run_begin_in = '0;
      rsp_run_end_in   = '0;
      rsp_status_in    = msri_pkg::STATUS_OK;
      pending_in       = pending_ff;
      if (accept) begin
         pending_in = 1'b1;
      end
      if (pending_ff && (cw.emit != msri_pkg::EM_NONE)) begin
         rsp_strobe_in = 1'b1;
         pending_in    = 1'b0;
         case (cw.emit)
            msri_pkg::EM_RANGE: rsp_status_in = msri_pkg::STATUS_RANGE;
            msri_pkg::EM_SAT:   rsp_status_in = msri_pkg::STATUS_SAT;
            msri_pkg::EM_READ:  rsp_value_in  = 16'(old_ff);
            msri_pkg::EM_INC: begin
               rsp_value_in     = 16'(old_inc);
               rsp_run_begin_in = 6'(ptr_inc);
               rsp_run_end_in   = {1'b0, pos_ff} + 7'd1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_opcode;
         pos_ff <= req_position;
      end
      ptr_ff           <= ptr_in;
      old_ff           <= old_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_run_begin_ff <= rsp_run_begin_in;
      rsp_run_end_ff   <= rsp_run_end_in;
      rsp_status_ff    <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         pending_ff    <= pending_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_run_begin = rsp_run_begin_ff;
   assign rsp_run_end   = rsp_run_end_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

@@ sv/monotone_sequence_run_increment.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// monotone_sequence_run_increment
// non-increasing counter sequence with read, run increment and clear,
// run by a small microprogram over a counter memory
// ---------------------------------------------------------------------------
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+--------------------------
//   request  | req_opcode, req_position                | taken when start & !busy
//   response | rsp_value, rsp_run_begin, rsp_run_end,  | one-cycle rsp_strobe,
//            | rsp_status                              | no back-pressure
//   csr      | csr_wr_data (length in use)             | written when csr_wr_en
//
// one word at a time; busy stays high from accept until the result word
// has been registered, and the response strobe shows as busy falls
// a read, a range error, an unused opcode, saturation and a clear each end in a
// single result word; a clear first zeroes all MAX_LENGTH counters
// increment raises each position from req_position downward that holds the value
// at req_position, then walks down over those one higher, up to MAX_LENGTH in all
// reset runs a clearing sweep over the counter memory with busy high;
// csr writes are taken throughout
// the receiver cannot stall, so every result word is shown exactly once
// ---------------------------------------------------------------------------
module monotone_sequence_run_increment #(
   parameter int MAX_LENGTH = msri_pkg::MAX_LENGTH_DEF,
   parameter int VALUE_BITS = msri_pkg::VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_position,
   // response
   output logic        rsp_strobe,
   output logic [15:0] rsp_value,
   output logic [5:0]  rsp_run_begin,
   output logic [6:0]  rsp_run_end,
   output logic [1:0]  rsp_status,
   // length register
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   msri_pkg::ctrl_word_type cw;
   msri_pkg::flags_type     flags;
   logic                    accept;
   logic [6:0]              len_ff;

   // a word enters only while the sequencer sits in its idle step
   assign accept = start && !busy;

   // length in use; values above MAX_LENGTH are clipped in the range check
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= msri_pkg::LEN_RESET;
      end else if (csr_wr_en) begin
         len_ff <= csr_wr_data;
      end
   end

   // control: step counter and control store
   msri_useq u_useq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .cw    (cw),
      .busy  (busy)
   );

   // datapath: counter memory, scan pointer and result register
   msri_dpath #(
      .MAX_LENGTH (MAX_LENGTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_opcode    (req_opcode),
      .req_position  (req_position),
      .len           (len_ff),
      .cw            (cw),
      .flags         (flags),
      .rsp_strobe    (rsp_strobe),
      .rsp_value     (rsp_value),
      .rsp_run_begin (rsp_run_begin),
      .rsp_run_end   (rsp_run_end),
      .rsp_status    (rsp_status)
   );

endmodule
